FILE: rtl/core/av_tc_pkg.sv
// av_tc_pkg: shared types and constants of the av timestamp corrector
// no dependencies; used by the stream interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none

package av_tc_pkg;

  localparam int unsigned KIND_W    = 2;
  localparam int unsigned TS_W      = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // packet kind codes, anything else is ignored
  localparam logic [KIND_W-1:0] KIND_AUDIO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VIDEO = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_MAX_STEP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_DEFAULT_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_MAX_STEP     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_DEFAULT_STEP = 2'd3;

  // configuration reset values
  localparam logic [CFG_W-1:0] RST_AUDIO_MAX_STEP     = 16'd100;
  localparam logic [CFG_W-1:0] RST_AUDIO_DEFAULT_STEP = 16'd23;
  localparam logic [CFG_W-1:0] RST_VIDEO_MAX_STEP     = 16'd100;
  localparam logic [CFG_W-1:0] RST_VIDEO_DEFAULT_STEP = 16'd40;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [TS_W-1:0]   stamp_t;
  typedef logic [CFG_W-1:0]  cfg_word_t;

endpackage

`default_nettype wire

FILE: rtl/core/av_tc_if.sv
// av_tc_in_if / av_tc_out_if: valid/ready stream channels of the corrector
// depends on av_tc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface av_tc_in_if;
  import av_tc_pkg::*;
  logic   valid;
  logic   ready;
  kind_t  packet_kind;
  stamp_t raw_timestamp;

  modport source (output valid, output packet_kind, output raw_timestamp, input ready);
  modport sink   (input valid, input packet_kind, input raw_timestamp, output ready);
endinterface

interface av_tc_out_if;
  import av_tc_pkg::*;
  logic   valid;
  logic   ready;
  stamp_t fixed_timestamp;

  modport source (output valid, output fixed_timestamp, input ready);
  modport sink   (input valid, input fixed_timestamp, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/av_timestamp_corrector.sv
// av_timestamp_corrector: an accepted input goes to the input register, then to the result
// register once it is free; one transaction per cycle while the result is not stalled; the
// input register feeds one pass of compare/add logic into the result register, which also
// updates the stream state; a stalled result holds both stages and drops input ready once
// the input register is full; rst_ni clears the pipeline valids and stream state and reloads
// the config defaults; depends on av_tc_pkg and av_tc_if
`timescale 1ns / 1ps
`default_nettype none

module av_timestamp_corrector #(
  parameter int unsigned STAMP_BITS = 32
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [av_tc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [av_tc_pkg::CFG_W-1:0]   cfg_wdata_i,
  av_tc_in_if.sink                     pkt_i,
  av_tc_out_if.source                  res_o
);
  import av_tc_pkg::*;

  localparam int unsigned SW = STAMP_BITS;
  // zero padding that brings a config word to SW+1 bits
  localparam int unsigned PAD = SW + 1 - CFG_W;

  // accept rule with replacement: raw - last must lie in 1..limit
  function automatic logic [SW-1:0] check_step(logic [SW-1:0] raw, logic [SW-1:0] last,
                                               cfg_word_t limit, cfg_word_t dflt);
    logic signed [SW:0] diff;
    logic        [SW:0] sum;
    logic signed [SW:0] lim;
    diff = $signed({1'b0, raw}) - $signed({1'b0, last});
    sum  = {1'b0, last} + {{PAD{1'b0}}, dflt};
    lim  = $signed({{PAD{1'b0}}, limit});
    if (diff <= 0 || diff > lim) begin
      return sum[SW-1:0];
    end
    return raw;
  endfunction

  // configuration registers
  cfg_word_t audio_max_q, audio_dflt_q, video_max_q, video_dflt_q;

  // stream state
  logic          audio_seen_q, audio_seen_d;
  logic          video_seen_q, video_seen_d;
  logic [SW-1:0] last_audio_q, last_audio_d;
  logic [SW-1:0] last_video_q, last_video_d;
  logic [1:0]    audio_run_q, audio_run_d;

  // input register stage
  logic          s1_valid_q;
  kind_t         s1_kind_q;
  logic [SW-1:0] s1_raw_q;

  // result register stage
  logic          out_valid_q;
  stamp_t        out_ts_q;

  logic          out_free;   // result register can take a new value this cycle
  logic          s1_fire;    // input register hands its transaction on
  logic          in_fire;    // input transaction accepted
  logic [SW-1:0] res_d;
  logic [1:0]    run_inc;
  logic signed [SW:0] gap;
  logic signed [SW:0] vmax_s;

  assign out_free    = !out_valid_q || res_o.ready;
  assign s1_fire     = s1_valid_q && out_free;
  assign pkt_i.ready = !s1_valid_q || out_free;
  assign in_fire     = pkt_i.valid && pkt_i.ready;

  assign res_o.valid           = out_valid_q;
  assign res_o.fixed_timestamp = out_ts_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      audio_max_q  <= RST_AUDIO_MAX_STEP;
      audio_dflt_q <= RST_AUDIO_DEFAULT_STEP;
      video_max_q  <= RST_VIDEO_MAX_STEP;
      video_dflt_q <= RST_VIDEO_DEFAULT_STEP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AUDIO_MAX_STEP:     audio_max_q  <= cfg_wdata_i;
        CFG_AUDIO_DEFAULT_STEP: audio_dflt_q <= cfg_wdata_i;
        CFG_VIDEO_MAX_STEP:     video_max_q  <= cfg_wdata_i;
        CFG_VIDEO_DEFAULT_STEP: video_dflt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // correction logic on the registered packet
  always_comb begin
    audio_seen_d = audio_seen_q;
    video_seen_d = video_seen_q;
    last_audio_d = last_audio_q;
    last_video_d = last_video_q;
    audio_run_d  = audio_run_q;
    res_d        = '0;
    // saturating count of audio frames since the last video frame
    run_inc      = (audio_run_q < 2'd2) ? audio_run_q + 2'd1 : 2'd2;
    // signed gap to the last audio stamp, used by the first video frame
    gap          = $signed({1'b0, s1_raw_q}) - $signed({1'b0, last_audio_q});
    vmax_s       = $signed({{PAD{1'b0}}, video_max_q});
    case (s1_kind_q)
      KIND_AUDIO: begin
        audio_run_d = run_inc;
        if (run_inc == 2'd2) begin
          // audio run under way: check against the audio timeline
          res_d = check_step(s1_raw_q, last_audio_q, audio_max_q, audio_dflt_q);
        end else if (audio_seen_q && video_seen_q) begin
          // first audio after a video frame: check against the video timeline
          res_d = check_step(s1_raw_q, last_video_q, video_max_q, video_dflt_q);
        end else begin
          res_d = s1_raw_q;
        end
        last_audio_d = res_d;
        audio_seen_d = 1'b1;
      end
      KIND_VIDEO: begin
        audio_run_d = 2'd0;
        if (!video_seen_q) begin
          // first video ever snaps to audio when the two are too far apart
          if (audio_seen_q && (gap < -vmax_s || gap > vmax_s)) begin
            res_d = last_audio_q;
          end else begin
            res_d = s1_raw_q;
          end
        end else begin
          res_d = check_step(s1_raw_q, last_video_q, video_max_q, video_dflt_q);
        end
        last_video_d = res_d;
        video_seen_d = 1'b1;
      end
      default: begin
        // ignored packet: result 0, state untouched
        res_d = '0;
      end
    endcase
  end

  // pipeline valids and stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      audio_seen_q <= 1'b0;
      video_seen_q <= 1'b0;
      last_audio_q <= '0;
      last_video_q <= '0;
      audio_run_q  <= 2'd0;
    end else begin
      if (pkt_i.ready) begin
        s1_valid_q <= pkt_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        audio_seen_q <= audio_seen_d;
        video_seen_q <= video_seen_d;
        last_audio_q <= last_audio_d;
        last_video_q <= last_video_d;
        audio_run_q  <= audio_run_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= pkt_i.packet_kind;
      s1_raw_q  <= pkt_i.raw_timestamp[SW-1:0];
    end
    if (s1_fire) begin
      out_ts_q <= TS_W'(res_d);
    end
  end

endmodule

`default_nettype wire

FILE: test/av_timestamp_corrector_test.sv
// av_timestamp_corrector_test: self-checking bench of the audio/video timestamp corrector
// runs directed and random packet streams under several register settings and checks
// every corrected stamp against its own predictor; depends on av_tc_pkg and av_tc_if
`timescale 1ns / 1ps

module av_timestamp_corrector_test;
  import av_tc_pkg::*;

  // kinds the block ignores
  localparam kind_t KIND_HEADER = 2'd2;
  localparam kind_t KIND_SPARE  = 2'd3;

  localparam int RANDOM_PER_PHASE = 200;

  typedef struct packed {
    kind_t  kind;
    stamp_t raw;
  } packet_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_AUDIO_MAX_STEP;
  cfg_word_t            cfg_wdata = '0;

  av_tc_in_if  pkt_if ();
  av_tc_out_if res_if ();

  av_timestamp_corrector #(
    .STAMP_BITS (32)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pkt_i       (pkt_if),
    .res_o       (res_if)
  );

  always #1 clk = ~clk;

  // packets waiting for the driver, stamps waiting for the block
  packet_t pending_pkts[$];
  stamp_t  fixed_stamp_q[$];

  int packets_queued = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int n_audio        = 0;
  int n_video        = 0;
  int n_ignored      = 0;
  int n_settings     = 0;

  // register copy used by the predictor, only changed while the block is idle
  cfg_word_t cfg_shadow [4] = '{RST_AUDIO_MAX_STEP, RST_AUDIO_DEFAULT_STEP,
                                RST_VIDEO_MAX_STEP, RST_VIDEO_DEFAULT_STEP};

  // predicted stream state
  logic       audio_seen = 1'b0;
  logic       video_seen = 1'b0;
  stamp_t     last_audio = '0;
  stamp_t     last_video = '0;
  logic [1:0] audio_run  = 2'd0;

  // stimulus cursors: rough idea of where each timeline stands
  stamp_t gen_audio       = '0;
  stamp_t gen_video       = '0;
  logic   gen_after_video = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // a step is good when raw - last, taken without wrap, lies in 1..limit
  function automatic stamp_t checked_step(stamp_t raw, stamp_t last, cfg_word_t limit,
                                          cfg_word_t dflt);
    longint diff;
    diff = longint'({32'h0, raw}) - longint'({32'h0, last});
    if (diff <= 0 || diff > longint'(limit)) return last + stamp_t'(dflt);
    return raw;
  endfunction

  function automatic stamp_t predict_fixed_stamp(kind_t kind, stamp_t raw);
    stamp_t fixed;
    longint gap;
    fixed = raw;
    if (kind == KIND_AUDIO) begin
      if (audio_run < 2'd2) audio_run = audio_run + 2'd1;
      if (audio_run >= 2'd2) begin
        fixed = checked_step(raw, last_audio, cfg_shadow[CFG_AUDIO_MAX_STEP],
                             cfg_shadow[CFG_AUDIO_DEFAULT_STEP]);
      end else if (audio_seen && video_seen) begin
        // first audio after a video frame follows the video timeline
        fixed = checked_step(raw, last_video, cfg_shadow[CFG_VIDEO_MAX_STEP],
                             cfg_shadow[CFG_VIDEO_DEFAULT_STEP]);
      end
      last_audio = fixed;
      audio_seen = 1'b1;
    end else if (kind == KIND_VIDEO) begin
      audio_run = 2'd0;
      if (!video_seen) begin
        // first video frame snaps to audio when the two are too far apart
        if (audio_seen) begin
          gap = longint'({32'h0, raw}) - longint'({32'h0, last_audio});
          if (gap < -longint'(cfg_shadow[CFG_VIDEO_MAX_STEP]) ||
              gap > longint'(cfg_shadow[CFG_VIDEO_MAX_STEP])) fixed = last_audio;
        end
      end else begin
        fixed = checked_step(raw, last_video, cfg_shadow[CFG_VIDEO_MAX_STEP],
                             cfg_shadow[CFG_VIDEO_DEFAULT_STEP]);
      end
      video_seen = 1'b1;
      last_video = fixed;
    end else begin
      fixed = '0;
    end
    return fixed;
  endfunction

  task automatic push_packet(input kind_t kind, input stamp_t raw);
    pending_pkts.push_back('{kind: kind, raw: raw});
    packets_queued++;
  endtask

  // mostly well-formed stream packets near the right timeline, plus noise
  task automatic queue_stream_packet();
    kind_t     kind;
    stamp_t    base;
    stamp_t    raw;
    cfg_word_t limit;
    cfg_word_t dflt;
    logic      good;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick >= 88) begin
      push_packet(kind_t'($urandom_range(0, 3)), stamp_t'($urandom()));
    end else if (pick >= 78) begin
      push_packet(kind_t'($urandom_range(KIND_HEADER, KIND_SPARE)), stamp_t'($urandom()));
    end else begin
      kind = (pick < 50) ? KIND_AUDIO : KIND_VIDEO;
      if (kind == KIND_AUDIO && !gen_after_video) begin
        base  = gen_audio;
        limit = cfg_shadow[CFG_AUDIO_MAX_STEP];
        dflt  = cfg_shadow[CFG_AUDIO_DEFAULT_STEP];
      end else begin
        base  = gen_video;
        limit = cfg_shadow[CFG_VIDEO_MAX_STEP];
        dflt  = cfg_shadow[CFG_VIDEO_DEFAULT_STEP];
      end
      good = 1'b0;
      case ($urandom_range(0, 15))
        0: raw = base;
        1: begin
          raw  = base + limit;
          good = (limit != 0);
        end
        2: raw = base + limit + 32'd1;
        3: raw = base - $urandom_range(1, 1000);
        default: begin
          raw  = base + $urandom_range(1, (limit == 0) ? 1 : limit);
          good = (limit != 0);
        end
      endcase
      push_packet(kind, raw);
      if (kind == KIND_AUDIO) begin
        gen_audio       = good ? raw : base + stamp_t'(dflt);
        gen_after_video = 1'b0;
      end else begin
        gen_video       = good ? raw : base + stamp_t'(dflt);
        gen_after_video = 1'b1;
      end
    end
  endtask

  // one register per cycle, enable dropped after the last one
  task automatic load_config(input cfg_word_t a_max, input cfg_word_t a_dflt,
                             input cfg_word_t v_max, input cfg_word_t v_dflt);
    cfg_word_t vals [4];
    vals = '{a_max, a_dflt, v_max, v_dflt};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_idx   <= i[CFG_IDX_W-1:0];
      cfg_wdata <= vals[i];
      cfg_shadow[i] = vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // waits until every queued packet has produced its result
  task automatic wait_idle();
    do @(negedge clk); while (results_seen != packets_queued);
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  logic in_taken   = 1'b0;
  int   burst_left = 0;
  int   gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      pkt_if.valid <= 1'b0;
    end else if (!pkt_if.valid || in_taken) begin
      // slot is free: either idle or the last transaction went through
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left > 0) begin
        gap_left--;
        pkt_if.valid <= 1'b0;
      end else if (pending_pkts.size() != 0) begin
        packet_t p;
        p = pending_pkts.pop_front();
        pkt_if.valid         <= 1'b1;
        pkt_if.packet_kind   <= p.kind;
        pkt_if.raw_timestamp <= p.raw;
        burst_left--;
      end else begin
        pkt_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: segments of always-ready, periodic stall and coin-flip ready
  // ---------------------------------------------------------------------------
  int seg_left = 0;
  int seg_mode = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 64);
        seg_mode = $urandom_range(0, 2);
      end
      seg_left--;
      case (seg_mode)
        0:       res_if.ready <= 1'b1;
        1:       res_if.ready <= (seg_left % 3 == 0);
        default: res_if.ready <= $urandom_range(0, 1);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each input transaction, check each result transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    stamp_t want;
    if (rst_n) begin
      in_taken <= pkt_if.valid && pkt_if.ready;
      if (pkt_if.valid && pkt_if.ready) begin
        fixed_stamp_q.push_back(predict_fixed_stamp(pkt_if.packet_kind,
                                                    pkt_if.raw_timestamp));
        if (pkt_if.packet_kind == KIND_AUDIO) n_audio++;
        else if (pkt_if.packet_kind == KIND_VIDEO) n_video++;
        else n_ignored++;
      end
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (fixed_stamp_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no packet pending",
                                    res_if.fixed_timestamp));
        end else begin
          want = fixed_stamp_q.pop_front();
          if (res_if.fixed_timestamp !== want)
            report_mismatch($sformatf("fixed_timestamp %h, expected %h (result %0d)",
                                      res_if.fixed_timestamp, want, results_seen));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    pkt_if.valid         = 1'b0;
    pkt_if.packet_kind   = KIND_HEADER;
    pkt_if.raw_timestamp = '0;
    res_if.ready         = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part under reset register values
    push_packet(KIND_HEADER, 32'hFFFF_FFFF);  // ignored kinds give 0
    push_packet(KIND_SPARE, 32'h5A5A_5A5A);
    push_packet(KIND_AUDIO, 32'hFFFF_FFF0);   // first audio passes through
    push_packet(KIND_AUDIO, 32'hFFFF_FFF0);   // zero step, replacement wraps
    push_packet(KIND_AUDIO, 32'd107);         // step exactly at the limit
    push_packet(KIND_AUDIO, 32'd208);         // one past the limit
    push_packet(KIND_AUDIO, 32'd0);           // backwards step
    push_packet(KIND_VIDEO, 32'd254);         // first video too far, snaps to audio
    push_packet(KIND_AUDIO, 32'd253);         // checked against video timeline
    push_packet(KIND_AUDIO, 32'd254);         // back on audio timeline
    push_packet(KIND_VIDEO, 32'd254);         // video step past the limit
    push_packet(KIND_AUDIO, 32'd193);         // zero step against video
    push_packet(KIND_AUDIO, 32'hFFFF_FFFF);   // huge audio step
    push_packet(KIND_VIDEO, 32'd194);
    push_packet(KIND_VIDEO, 32'd0);
    push_packet(KIND_HEADER, 32'd0);          // ignored mid stream keeps state
    push_packet(KIND_AUDIO, 32'd284);
    push_packet(KIND_SPARE, 32'hFFFF_FFFF);
    push_packet(KIND_AUDIO, 32'd300);
    push_packet(KIND_VIDEO, 32'd300);
    push_packet(KIND_AUDIO, 32'd350);
    gen_audio       = 32'd350;
    gen_video       = 32'd300;
    gen_after_video = 1'b0;

    // random phases, registers rewritten only between them
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: ;  // keep reset values
        1: load_config(cfg_word_t'($urandom_range(0, 65535)),
                       cfg_word_t'($urandom_range(0, 65535)),
                       cfg_word_t'($urandom_range(0, 65535)),
                       cfg_word_t'($urandom_range(0, 65535)));
        2: load_config(16'd0, 16'd0, 16'd0, 16'd0);
        3: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: load_config(16'd10, 16'hFFFF, 16'hFFFF, 16'd1);
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) queue_stream_packet();
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (fixed_stamp_q.size() != 0)
      report_mismatch($sformatf("%0d expected stamps never arrived", fixed_stamp_q.size()));
    $display("covered %0d audio, %0d video and %0d ignored packets, %0d results checked",
             n_audio, n_video, n_ignored, results_seen);
    $display("register settings: reset values plus %0d written sets, %0d mismatches",
             n_settings, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
